@@ hdl/rc4_pkg.sv @@
// shared types and codes for the rc4 stream cipher block
// payload structs, operation and status codes, controller to datapath command/status
// no dependencies
package rc4_pkg;

  localparam int MAX_KEY_BYTES_DEF = 256;
  localparam int BOX_SIZE          = 256;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_SCHED  = 2'd2;
  localparam logic [1:0] OP_DATA   = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NOKEY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // state box port operations
  localparam logic [2:0] MEM_NONE     = 3'd0;
  localparam logic [2:0] MEM_FILL     = 3'd1;
  localparam logic [2:0] MEM_RD_INEXT = 3'd2;
  localparam logic [2:0] MEM_RD_I     = 3'd3;
  localparam logic [2:0] MEM_RD_J     = 3'd4;
  localparam logic [2:0] MEM_WR_I     = 3'd5;
  localparam logic [2:0] MEM_WR_J     = 3'd6;
  localparam logic [2:0] MEM_RD_T     = 3'd7;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] byte_in;
  } req_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [1:0] status;
  } rsp_t;

  typedef struct packed {
    logic [2:0] mem_op;
    logic       use_key;
    logic       load_byte;
    logic       clear;
    logic       append;
    logic       sched_init;
    logic       ksa_adv;
    logic       sched_done;
    logic       keyed_clr;
    logic       res_load;
    logic       res_xor;
    logic [1:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic key_full;
    logic key_empty;
    logic keyed;
    logic idx_last;
  } sts_t;

endpackage

@@ hdl/rc4_ctrl.sv @@
// sequencer for the rc4 block: handshakes, fill, key schedule and keystream steps
// drives datapath commands, watches datapath status
// depends on rc4_pkg
module rc4_ctrl import rc4_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] operation,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  input  sts_t       sts,
  output cmd_t       cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FILL  = 4'd1;
  localparam logic [3:0] S_K0    = 4'd2;
  localparam logic [3:0] S_K1    = 4'd3;
  localparam logic [3:0] S_K2    = 4'd4;
  localparam logic [3:0] S_K3    = 4'd5;
  localparam logic [3:0] S_KDONE = 4'd6;
  localparam logic [3:0] S_X0    = 4'd7;
  localparam logic [3:0] S_X1    = 4'd8;
  localparam logic [3:0] S_X2    = 4'd9;
  localparam logic [3:0] S_X3    = 4'd10;
  localparam logic [3:0] S_X4    = 4'd11;
  localparam logic [3:0] S_X5    = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;

  // output register must be empty or draining before a new beat comes in
  assign req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;

  always_comb begin
    cmd        = '0;
    cmd.mem_op = MEM_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load_byte = 1'b1;
          case (operation)
            OP_CLEAR: begin
              cmd.clear      = 1'b1;
              cmd.res_load   = 1'b1;
              cmd.res_status = STAT_OK;
            end
            OP_APPEND: begin
              cmd.res_load = 1'b1;
              if (sts.key_full) begin
                cmd.res_status = STAT_FULL;
              end else begin
                cmd.append     = 1'b1;
                cmd.res_status = STAT_OK;
              end
            end
            OP_SCHED: begin
              if (sts.key_empty) begin
                cmd.keyed_clr  = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = STAT_NOKEY;
              end else begin
                cmd.sched_init = 1'b1;
                state_next     = S_FILL;
              end
            end
            default: begin
              if (!sts.keyed) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = STAT_NOKEY;
              end else begin
                state_next = S_X0;
              end
            end
          endcase
        end
      end
      S_FILL: begin
        cmd.mem_op = MEM_FILL;
        if (sts.idx_last) state_next = S_K0;
      end
      S_K0: begin
        cmd.mem_op = MEM_RD_I;
        state_next = S_K1;
      end
      S_K1: begin
        cmd.mem_op  = MEM_RD_J;
        cmd.use_key = 1'b1;
        state_next  = S_K2;
      end
      S_K2: begin
        cmd.mem_op = MEM_WR_I;
        state_next = S_K3;
      end
      S_K3: begin
        cmd.mem_op  = MEM_WR_J;
        cmd.ksa_adv = 1'b1;
        state_next  = sts.idx_last ? S_KDONE : S_K0;
      end
      S_KDONE: begin
        cmd.sched_done = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = STAT_OK;
        state_next     = S_IDLE;
      end
      S_X0: begin
        cmd.mem_op = MEM_RD_INEXT;
        state_next = S_X1;
      end
      S_X1: begin
        cmd.mem_op = MEM_RD_J;
        state_next = S_X2;
      end
      S_X2: begin
        cmd.mem_op = MEM_WR_I;
        state_next = S_X3;
      end
      S_X3: begin
        cmd.mem_op = MEM_WR_J;
        state_next = S_X4;
      end
      S_X4: begin
        cmd.mem_op = MEM_RD_T;
        state_next = S_X5;
      end
      S_X5: begin
        cmd.res_load   = 1'b1;
        cmd.res_xor    = 1'b1;
        cmd.res_status = STAT_OK;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/rc4_dp.sv @@
// datapath for the rc4 block: state box and key store memories, indices, result register
// acts on commands from rc4_ctrl and reports status back
// depends on rc4_pkg
module rc4_dp import rc4_pkg::*; #(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output rsp_t rsp
);

  localparam int KCW = $clog2(MAX_KEY_BYTES + 1);
  localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int BAW = $clog2(BOX_SIZE);

  logic [7:0]     sbox [BOX_SIZE];
  logic [7:0]     kmem [MAX_KEY_BYTES];

  logic [BAW-1:0] mem_addr;
  logic           mem_we;
  logic [7:0]     mem_wdata;
  logic [7:0]     mem_rdata;
  logic [7:0]     key_rdata;

  logic [KCW-1:0] key_count;
  logic [KAW-1:0] kpos;
  logic [KCW-1:0] kpos_inc;
  logic [BAW-1:0] idx_i;
  logic [BAW-1:0] idx_j;
  logic [BAW-1:0] j_sum;
  logic           keyed;
  logic [7:0]     si;
  logic [7:0]     sj;
  logic [7:0]     data;

  assign kpos_inc = KCW'(kpos) + KCW'(1);
  assign j_sum    = idx_j + mem_rdata + (cmd.use_key ? key_rdata : 8'd0);

  always_comb begin
    mem_addr  = idx_i;
    mem_we    = 1'b0;
    mem_wdata = mem_rdata;
    case (cmd.mem_op)
      MEM_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = idx_i;
      end
      MEM_RD_INEXT: mem_addr = idx_i + 8'd1;
      MEM_RD_I:     mem_addr = idx_i;
      MEM_RD_J:     mem_addr = j_sum;
      MEM_WR_I: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      MEM_WR_J: begin
        mem_addr  = idx_j;
        mem_we    = 1'b1;
        mem_wdata = si;
      end
      MEM_RD_T:     mem_addr = si + sj;
      default:      mem_addr = idx_i;
    endcase
  end

  // single port state box, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) sbox[mem_addr] <= mem_wdata;
    mem_rdata <= sbox[mem_addr];
  end

  // key store: append writes at the fill count, schedule reads at kpos
  always_ff @(posedge clk) begin
    if (cmd.append) kmem[key_count[KAW-1:0]] <= req.byte_in;
    key_rdata <= kmem[kpos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
      kpos      <= '0;
      idx_i     <= '0;
      idx_j     <= '0;
      keyed     <= 1'b0;
    end else begin
      if (cmd.clear) begin
        key_count <= '0;
        idx_i     <= '0;
        idx_j     <= '0;
        keyed     <= 1'b0;
      end
      if (cmd.append) key_count <= key_count + KCW'(1);
      if (cmd.keyed_clr) keyed <= 1'b0;
      if (cmd.sched_init) begin
        idx_i <= '0;
        idx_j <= '0;
        kpos  <= '0;
      end
      if (cmd.mem_op == MEM_FILL || cmd.mem_op == MEM_RD_INEXT) idx_i <= idx_i + 8'd1;
      if (cmd.mem_op == MEM_RD_J) idx_j <= j_sum;
      if (cmd.ksa_adv) begin
        idx_i <= idx_i + 8'd1;
        // key position wraps at the key length
        if (kpos_inc >= key_count) begin
          kpos <= '0;
        end else begin
          kpos <= kpos_inc[KAW-1:0];
        end
      end
      if (cmd.sched_done) begin
        idx_j <= '0;
        keyed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) data <= req.byte_in;
    if (cmd.mem_op == MEM_RD_J) si <= mem_rdata;
    if (cmd.mem_op == MEM_WR_I) sj <= mem_rdata;
    if (cmd.res_load) begin
      rsp.byte_out <= cmd.res_xor ? (data ^ mem_rdata) : 8'd0;
      rsp.status   <= cmd.res_status;
    end
  end

  assign sts.key_full  = (key_count == KCW'(MAX_KEY_BYTES));
  assign sts.key_empty = (key_count == '0);
  assign sts.keyed     = keyed;
  assign sts.idx_last  = (idx_i == 8'hff);

endmodule

@@ hdl/rc4_stream_cipher.sv @@
// RC4 stream cipher engine: request and response channels with valid/stall handshake.
// A request beat carries an operation (clear, append key byte, run key schedule,
// process data byte) and a byte; every request gives exactly one response beat
// with the output byte and a status code.
// Clear, append and any rejected operation: the response is registered at the
// accept edge and shows in the next cycle; the next request can follow at once.
// Data byte: the keystream step walks read i, read j, two swap writes and the
// final read through the single port of the state box, then loads the result;
// no new request is taken until the step is done.
// Key schedule: identity fill of all 256 state box entries, then 256 permutation
// steps of read i, read j and two swap writes; no new request is taken meanwhile.
// Reset clears the indices, the key count and the keyed flag; the memories are
// not cleared, there is no clearing pass, and requests are taken right away.
// While the receiver stalls, the response beat holds and no new request is taken
// once the output register is full.
// depends on rc4_pkg, rc4_ctrl, rc4_dp
module rc4_stream_cipher import rc4_pkg::*; #(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  cmd_t cmd;
  sts_t sts;

  rc4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .operation (req.operation),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rc4_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule
